/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files of the complex FIR filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define CFIR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CFIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CFIR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define CFIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/cfir_pkg.sv */
// Types and constants shared by the complex FIR filter modules.
`timescale 1ns / 1ps

package cfir_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 16;
  localparam int TAP_COUNT_BITS = 7;
  localparam int TAP_SEL_BITS   = 6;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TAP_COUNT    = 3'd0,
    CFG_TAP_SELECT   = 3'd1,
    CFG_TAP_REAL     = 3'd2,
    CFG_TAP_IMAG     = 3'd3,
    CFG_COMPLEX_TAPS = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_real;
    logic signed [SAMPLE_BITS-1:0] sample_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_real;
    logic signed [SAMPLE_BITS-1:0] out_imag;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
  } smp_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] re;
    logic signed [COEF_BITS-1:0] im;
  } tap_t;

  // Control broadcast from the sequencer to every cell of the ring.
  typedef struct packed {
    logic                    shift;
    logic                    rotate;
    logic                    clear;
    logic                    wr_en;
    logic [TAP_SEL_BITS-1:0] wr_sel;
    tap_t                    wr_tap;
  } cell_ctl_t;

  // Per-step control for the shared multiply-accumulate unit.
  typedef struct packed {
    logic valid;
    logic first;
    logic tap_on;
    logic last;
  } mac_ctl_t;

endpackage

/* hw/rtl/cfir_cell.sv */
// One ring cell: holds one window sample and one coefficient.
`timescale 1ns / 1ps

module cfir_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfir_pkg::cell_ctl_t ctl,
  input  cfir_pkg::smp_t      shift_in,
  input  cfir_pkg::smp_t      rot_smp_in,
  input  cfir_pkg::tap_t      rot_tap_in,
  output cfir_pkg::smp_t      smp_out,
  output cfir_pkg::tap_t      tap_out
);

  cfir_pkg::smp_t smp_r, smp_nxt;
  cfir_pkg::tap_t tap_r, tap_nxt;
  logic           sel_hit;

  assign sel_hit = ctl.wr_en && (int'(ctl.wr_sel) == CELL_IDX);

  always_comb begin
    priority if (ctl.clear) begin
      smp_nxt = '0;
    end else if (ctl.shift) begin
      smp_nxt = shift_in;
    end else if (ctl.rotate) begin
      smp_nxt = rot_smp_in;
    end else begin
      smp_nxt = smp_r;
    end
  end

  always_comb begin
    priority if (sel_hit) begin
      tap_nxt = ctl.wr_tap;
    end else if (ctl.rotate) begin
      tap_nxt = rot_tap_in;
    end else begin
      tap_nxt = tap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r <= '0;
      tap_r <= '0;
    end else begin
      smp_r <= smp_nxt;
      tap_r <= tap_nxt;
    end
  end

  assign smp_out = smp_r;
  assign tap_out = tap_r;

endmodule

/* hw/rtl/cfir_mac.sv */
// Shared complex multiply-accumulate unit with rounding and saturation.
`timescale 1ns / 1ps

module cfir_mac #(
  parameter int MAX_TAPS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfir_pkg::mac_ctl_t  ctl,
  input  cfir_pkg::smp_t      smp,
  input  cfir_pkg::tap_t      tap,
  input  logic                complex_taps,
  output logic                done,
  output cfir_pkg::out_item_t result
);

  localparam int SB    = cfir_pkg::SAMPLE_BITS;
  localparam int CB    = cfir_pkg::COEF_BITS;
  localparam int PW    = SB + CB;
  localparam int ACC_W = PW + 1 + $clog2(MAX_TAPS);
  localparam logic [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (CB - 2);

  logic signed [CB-1:0]    tap_im;
  logic signed [PW-1:0]    prr_r, pii_r, pri_r, pir_r;
  logic signed [PW-1:0]    prr_nxt, pii_nxt, pri_nxt, pir_nxt;
  logic                    v1_r, first1_r, tap_on1_r, last1_r;
  logic signed [ACC_W-1:0] term_re, term_im;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r, acc_re_nxt, acc_im_nxt;
  logic                    done_r;

  // Round half up by CB-1 bits, then clamp to the sample range.
  function automatic logic signed [SB-1:0] rnd_sat(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-1:0]      sum;
    logic [ACC_W-CB:0]     sh;
    logic                  ovf;
    logic signed [SB-1:0]  r;
    sum = a + HALF;
    sh  = sum[ACC_W-1:CB-1];
    ovf = !((&sh[ACC_W-CB:SB-1]) || !(|sh[ACC_W-CB:SB-1]));
    if (ovf) begin
      r = sh[ACC_W-CB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end else begin
      r = sh[SB-1:0];
    end
    return r;
  endfunction

  assign tap_im  = complex_taps ? tap.im : '0;
  assign prr_nxt = smp.re * tap.re;
  assign pii_nxt = smp.im * tap_im;
  assign pri_nxt = smp.re * tap_im;
  assign pir_nxt = smp.im * tap.re;

  always_ff @(posedge clk) begin
    prr_r <= prr_nxt;
    pii_r <= pii_nxt;
    pri_r <= pri_nxt;
    pir_r <= pir_nxt;
    first1_r  <= ctl.first;
    tap_on1_r <= ctl.tap_on;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      last1_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      v1_r    <= ctl.valid;
      last1_r <= ctl.valid && ctl.last;
      done_r  <= v1_r && last1_r;
    end
  end

  assign term_re = tap_on1_r ? (ACC_W'(prr_r) - ACC_W'(pii_r)) : '0;
  assign term_im = tap_on1_r ? (ACC_W'(pri_r) + ACC_W'(pir_r)) : '0;

  always_comb begin
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    if (v1_r) begin
      acc_re_nxt = (first1_r ? '0 : acc_re_r) + term_re;
      acc_im_nxt = (first1_r ? '0 : acc_im_r) + term_im;
    end
  end

  always_ff @(posedge clk) begin
    acc_re_r <= acc_re_nxt;
    acc_im_r <= acc_im_nxt;
  end

  assign done            = done_r;
  assign result.out_real = rnd_sat(acc_re_r);
  assign result.out_imag = rnd_sat(acc_im_r);

endmodule

/* hw/rtl/complex_fir_filter.sv */
// Top level of the streaming complex FIR filter.
`timescale 1ns / 1ps

// Complex FIR filter on Q1.15 samples with real or complex Q1.15 taps. The
// sample window and the coefficients live in a ring of MAX_TAPS cells. When a
// sample is accepted it is shifted into cell 0 in that same cycle. If enough
// samples have been seen (more than the effective tap count N since reset or
// the last filter change), the ring then rotates once around, one cell per
// cycle, feeding cell 0 into a single pipelined complex multiply-accumulate
// unit; taps at or above N are skipped. A sample that yields a result
// therefore occupies the block through its accept, MAX_TAPS rotation
// steps, two MAC pipeline stages and the load of the output register,
// set by the full rotation of the ring through the one shared MAC. A
// sample that yields no result only shifts the ring, with no rotation. The
// finished result sits in an output register, so the next sample may be
// accepted while that result still waits to be taken. The sum is kept at
// full precision, rounded half up by 15 bits and saturated to 16 bits.
// Writing tap_count, complex_taps or tap_imag (which commits the pending
// coefficient at tap_select) clears the window and the sample count.
// Configuration writes are taken only while the block is idle, and a
// configuration write offered in that state goes ahead of a waiting sample,
// which is stalled for that cycle.

`include "assert_macros.svh"

module complex_fir_filter #(
  parameter int MAX_TAPS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input sample channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  cfir_pkg::in_item_t                    in_data,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output cfir_pkg::out_item_t                   out_data,
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cfir_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [cfir_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  // Width of the tap step counter and of counts that can reach MAX_TAPS.
  localparam int KW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int NW = $clog2(MAX_TAPS + 1);

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [cfir_pkg::TAP_COUNT_BITS-1:0] tap_count_r, tap_count_nxt;
  logic [cfir_pkg::TAP_SEL_BITS-1:0]   tap_select_r, tap_select_nxt;
  logic signed [cfir_pkg::COEF_BITS-1:0] tap_real_r, tap_real_nxt;
  logic                                complex_taps_r, complex_taps_nxt;

  logic cfg_xfer;
  logic win_clear;
  logic tap_commit;

  assign cfg_xfer = cfg_valid && cfg_ready;

  // Decode a configuration transfer. Any filter change also clears the
  // window, so the ring and the sample count restart from zero.
  always_comb begin
    tap_count_nxt    = tap_count_r;
    tap_select_nxt   = tap_select_r;
    tap_real_nxt     = tap_real_r;
    complex_taps_nxt = complex_taps_r;
    win_clear        = 1'b0;
    tap_commit       = 1'b0;
    if (cfg_xfer) begin
      unique case (cfir_pkg::cfg_reg_t'(cfg_index))
        cfir_pkg::CFG_TAP_COUNT: begin
          tap_count_nxt = cfg_data[cfir_pkg::TAP_COUNT_BITS-1:0];
          win_clear     = 1'b1;
        end
        cfir_pkg::CFG_TAP_SELECT: begin
          tap_select_nxt = cfg_data[cfir_pkg::TAP_SEL_BITS-1:0];
        end
        cfir_pkg::CFG_TAP_REAL: begin
          tap_real_nxt = cfg_data[cfir_pkg::COEF_BITS-1:0];
        end
        cfir_pkg::CFG_TAP_IMAG: begin
          tap_commit = int'(tap_select_r) < MAX_TAPS;
          win_clear  = 1'b1;
        end
        cfir_pkg::CFG_COMPLEX_TAPS: begin
          complex_taps_nxt = cfg_data[0];
          win_clear        = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r    <= cfir_pkg::TAP_COUNT_BITS'(1);
      tap_select_r   <= '0;
      tap_real_r     <= '0;
      complex_taps_r <= 1'b0;
    end else begin
      tap_count_r    <= tap_count_nxt;
      tap_select_r   <= tap_select_nxt;
      tap_real_r     <= tap_real_nxt;
      complex_taps_r <= complex_taps_nxt;
    end
  end

  // Effective tap count: zero acts as one, and counts above MAX_TAPS clamp.
  logic [NW-1:0] n_taps;
  int            tc_int;

  assign tc_int = int'(tap_count_r);
  assign n_taps = (tc_int == 0)        ? NW'(1) :
                  (tc_int > MAX_TAPS)  ? NW'(MAX_TAPS) : NW'(tc_int);

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  cfir_pkg::state_t state_r, state_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [NW-1:0]    seen_r, seen_nxt;
  logic             in_xfer;
  logic             emit;
  logic             k_last;
  logic             mac_done;
  logic             out_free;
  logic             load_out;
  logic             ring_rotate;

  assign in_xfer  = in_valid && !in_stall;
  assign emit     = seen_r >= n_taps;
  assign k_last   = int'(k_r) == (MAX_TAPS - 1);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfir_pkg::ST_IDLE: begin
        if (in_xfer && emit) begin
          state_nxt = cfir_pkg::ST_RUN;
        end
      end
      cfir_pkg::ST_RUN: begin
        if (k_last) begin
          state_nxt = cfir_pkg::ST_DRAIN;
        end
      end
      cfir_pkg::ST_DRAIN: begin
        if (mac_done) begin
          state_nxt = cfir_pkg::ST_HOLD;
        end
      end
      cfir_pkg::ST_HOLD: begin
        if (out_free) begin
          state_nxt = cfir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cfir_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cfg_ready   = 1'b0;
    ring_rotate = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      cfir_pkg::ST_IDLE: begin
        // A configuration write takes the cycle; the sample waits behind it.
        in_stall  = cfg_valid;
        cfg_ready = 1'b1;
      end
      cfir_pkg::ST_RUN: begin
        ring_rotate = 1'b1;
      end
      cfir_pkg::ST_DRAIN: begin
      end
      cfir_pkg::ST_HOLD: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  // The step counter names the tap that cell 0 currently holds.
  always_comb begin
    k_nxt = k_r;
    if (ring_rotate) begin
      k_nxt = k_r + KW'(1);
    end else if (state_r == cfir_pkg::ST_IDLE) begin
      k_nxt = '0;
    end
  end

  always_comb begin
    seen_nxt = seen_r;
    if (win_clear) begin
      seen_nxt = '0;
    end else if (in_xfer && !emit) begin
      seen_nxt = seen_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfir_pkg::ST_IDLE;
      k_r     <= '0;
      seen_r  <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      seen_r  <= seen_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Ring of cells. A shift moves samples toward higher indexes with the new
  // sample entering cell 0; a rotation moves samples and taps toward cell 0,
  // with cell 0 wrapping around to the last cell.
  // --------------------------------------------------------------------------
  cfir_pkg::cell_ctl_t cell_ctl;
  cfir_pkg::smp_t      smp_q [MAX_TAPS];
  cfir_pkg::tap_t      tap_q [MAX_TAPS];
  cfir_pkg::smp_t      new_smp;

  assign new_smp.re = in_data.sample_real;
  assign new_smp.im = in_data.sample_imag;

  assign cell_ctl.shift     = in_xfer;
  assign cell_ctl.rotate    = ring_rotate;
  assign cell_ctl.clear     = win_clear;
  assign cell_ctl.wr_en     = tap_commit;
  assign cell_ctl.wr_sel    = tap_select_r;
  assign cell_ctl.wr_tap.re = tap_real_r;
  assign cell_ctl.wr_tap.im = cfg_data[cfir_pkg::COEF_BITS-1:0];

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    localparam int NEXT = (j + 1) % MAX_TAPS;
    cfir_pkg::smp_t shift_src;

    if (j == 0) begin : g_head
      assign shift_src = new_smp;
    end else begin : g_body
      assign shift_src = smp_q[j-1];
    end

    cfir_cell #(
      .CELL_IDX (j)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl),
      .shift_in   (shift_src),
      .rot_smp_in (smp_q[NEXT]),
      .rot_tap_in (tap_q[NEXT]),
      .smp_out    (smp_q[j]),
      .tap_out    (tap_q[j])
    );
  end

  // --------------------------------------------------------------------------
  // Shared multiply-accumulate unit fed from cell 0.
  // --------------------------------------------------------------------------
  cfir_pkg::mac_ctl_t  mac_ctl;
  cfir_pkg::out_item_t mac_res;

  assign mac_ctl.valid  = ring_rotate;
  assign mac_ctl.first  = k_r == '0;
  assign mac_ctl.tap_on = int'(k_r) < int'(n_taps);
  assign mac_ctl.last   = k_last;

  cfir_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (mac_ctl),
    .smp          (smp_q[0]),
    .tap          (tap_q[0]),
    .complex_taps (complex_taps_r),
    .done         (mac_done),
    .result       (mac_res)
  );

  // --------------------------------------------------------------------------
  // Output register. It frees the datapath as soon as a result is loaded.
  // --------------------------------------------------------------------------
  logic                out_valid_r, out_valid_nxt;
  cfir_pkg::out_item_t out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= mac_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `CFIR_ASSERT_SAME(a_seen_bounded, clk, rst_n, 1'b1, seen_r <= n_taps, "sample count above tap count")
  `CFIR_ASSERT_SAME(a_done_in_drain, clk, rst_n, mac_done, state_r == cfir_pkg::ST_DRAIN, "MAC finished outside drain")
  `CFIR_ASSERT_SAME(a_out_from_hold, clk, rst_n, $rose(out_valid_r), $past(state_r) == cfir_pkg::ST_HOLD, "result appeared without a finished sum")
  `CFIR_ASSERT_NEXT(a_emit_starts_run, clk, rst_n, in_xfer && emit, state_r == cfir_pkg::ST_RUN, "emitting sample did not start the ring")

endmodule
